FILE: sv/assert_macros.svh
// Assertion macros for the RTL of the range distinct-count block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define RDCW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("property violated");

// Expression must never be true at a rising edge outside reset.
`define RDCW_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

FILE: sv/rdcw_pkg.sv
// Package with the shared widths, defaults, codes and types of the block.
package rdcw_pkg;

    localparam int IDX_W = 10;
    localparam int VAL_W = 10;
    localparam int LEN_W = 11;
    localparam int DC_W  = 11;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_VALUE_RANGE  = 1024;

    typedef logic [LEN_W-1:0] len_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [VAL_W-1:0] val_t;
    typedef logic [DC_W-1:0]  dcount_t;

    localparam len_t LEN_RESET = len_t'(1024);

    typedef enum logic
    {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_ELEM,
        ST_FREQ,
        ST_LOAD_WR,
        ST_DONE
    } state_t;

endpackage

FILE: sv/rdcw_if.sv
// Request and result channel interfaces of the range distinct-count block.
interface rdcw_req_if;
    import rdcw_pkg::*;

    logic    valid;
    logic    ready;
    action_t action;
    idx_t    elem_index;
    val_t    elem_value;
    idx_t    range_left;
    idx_t    range_right;

    modport source
    (
        output valid, action, elem_index, elem_value, range_left, range_right,
        input  ready
    );

    modport sink
    (
        input  valid, action, elem_index, elem_value, range_left, range_right,
        output ready
    );
endinterface

interface rdcw_rsp_if;
    import rdcw_pkg::*;

    logic    valid;
    logic    ready;
    dcount_t distinct_count;
    logic    range_error;

    modport source
    (
        output valid, distinct_count, range_error,
        input  ready
    );

    modport sink
    (
        input  valid, distinct_count, range_error,
        output ready
    );
endinterface

FILE: sv/range_distinct_count_window.sv
// A load inside the window removes the old element and adds the new one through the element
// and frequency states before its write; a load outside goes straight to the write, a refused
// request straight to the finishing state. A query walks the window one element at a time.
// One request is in work at a time and the next is taken once its result is registered; a
// waiting result holds back only the following one. After reset a clearing pass zeroes the
// frequency table without taking requests; configuration writes are taken throughout.
module range_distinct_count_window
#(
    parameter int MAX_ELEMENTS = rdcw_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_RANGE  = rdcw_pkg::DEF_VALUE_RANGE
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  rdcw_pkg::len_t cfg_wr_data,
    rdcw_req_if.sink       request,
    rdcw_rsp_if.source     result
);

    import rdcw_pkg::*;

    `include "assert_macros.svh"

    // Window edges and counts must hold the full element count, so they
    // are one bit wider than an element address.
    localparam int POS_W = $clog2(MAX_ELEMENTS + 1);
    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int VAW   = $clog2(VALUE_RANGE);
    localparam int CNT_W = POS_W;
    localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [CMP_W-1:0] cmp_t;
    typedef logic [VAW-1:0]   vaddr_t;
    typedef logic [AW-1:0]    eaddr_t;

    // Sequencer and datapath registers.
    state_t  state_reg,    state_next;
    len_t    length_reg;
    pos_t    left_reg,     left_next;
    pos_t    end_reg,      end_next;
    cnt_t    distinct_reg, distinct_next;
    pos_t    lo_reg,       lo_next;
    pos_t    tgt_reg,      tgt_next;
    eaddr_t  idx_reg,      idx_next;
    val_t    nval_reg,     nval_next;
    logic    load_reg,     load_next;
    logic    phase_reg,    phase_next;
    logic    dir_reg,      dir_next;
    logic    err_reg,      err_next;
    vaddr_t  fval_reg,     fval_next;
    logic    fok_reg,      fok_next;
    vaddr_t  clr_reg,      clr_next;

    // Result register.
    logic    out_valid_reg, out_valid_next;
    dcount_t out_count_reg, out_count_next;
    logic    out_err_reg,   out_err_next;

    // Memory ports.
    logic   ewe, ere;
    eaddr_t ewaddr, eraddr;
    val_t   ewdata, erdata;
    logic   fwe, fre;
    vaddr_t fwaddr, fraddr;
    cnt_t   fwdata, frdata;

    // Decoded conditions.
    logic   accept;
    logic   is_query;
    logic   q_err;
    logic   load_ok;
    logic   in_window;
    logic   left_gt, end_lt, left_lt, end_gt, walk_any;
    logic   out_free;
    logic   cur_dir;
    cmp_t   len_eff;
    cmp_t   hi_p1;
    val_t   cur_val;

    rdcw_ram
    #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ELEMENTS)
    )
    u_elem_ram
    (
        .clk   (clk),
        .we    (ewe),
        .waddr (ewaddr),
        .wdata (ewdata),
        .re    (ere),
        .raddr (eraddr),
        .rdata (erdata)
    );

    rdcw_ram
    #(
        .WIDTH (CNT_W),
        .DEPTH (VALUE_RANGE)
    )
    u_freq_ram
    (
        .clk   (clk),
        .we    (fwe),
        .waddr (fwaddr),
        .wdata (fwdata),
        .re    (fre),
        .raddr (fraddr),
        .rdata (frdata)
    );

    assign request.ready         = (state_reg == ST_IDLE);
    assign accept                = request.valid && request.ready;
    assign result.valid          = out_valid_reg;
    assign result.distinct_count = out_count_reg;
    assign result.range_error    = out_err_reg;

    // Decoding of the incoming request and of the walk towards the target
    // window. The walk first grows the window on both sides and only then
    // shrinks it, so the left edge never passes the end edge.
    always_comb
    begin
        is_query  = (request.action == ACT_QUERY);
        len_eff   = (32'(length_reg) > MAX_ELEMENTS) ? cmp_t'(MAX_ELEMENTS)
                                                     : cmp_t'(length_reg);
        hi_p1     = cmp_t'(request.range_right) + cmp_t'(1);
        q_err     = (cmp_t'(request.range_left) > hi_p1) ||
                    (cmp_t'(request.range_right) >= len_eff);
        load_ok   = (32'(request.elem_index) < MAX_ELEMENTS) &&
                    (32'(request.elem_value) < VALUE_RANGE);
        in_window = (cmp_t'(request.elem_index) >= cmp_t'(left_reg)) &&
                    (cmp_t'(request.elem_index) < cmp_t'(end_reg));

        left_gt  = left_reg > lo_reg;
        end_lt   = end_reg < tgt_reg;
        left_lt  = left_reg < lo_reg;
        end_gt   = end_reg > tgt_reg;
        walk_any = left_gt || end_lt || left_lt || end_gt;

        out_free = !out_valid_reg || result.ready;

        // A load first removes the old element and then adds the new one.
        cur_dir = load_reg ? phase_reg : dir_reg;
        cur_val = (load_reg && phase_reg) ? nval_reg : erdata;
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == vaddr_t'(VALUE_RANGE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_query)
                    begin
                        state_next = q_err ? ST_DONE : ST_WALK;
                    end
                    else if (!load_ok)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = in_window ? ST_ELEM : ST_LOAD_WR;
                    end
                end
            end
            ST_WALK:
            begin
                state_next = walk_any ? ST_ELEM : ST_DONE;
            end
            ST_ELEM:
            begin
                state_next = ST_FREQ;
            end
            ST_FREQ:
            begin
                if (load_reg)
                begin
                    state_next = phase_reg ? ST_LOAD_WR : ST_ELEM;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_LOAD_WR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls for each sequencer state.
    always_comb
    begin
        left_next      = left_reg;
        end_next       = end_reg;
        distinct_next  = distinct_reg;
        lo_next        = lo_reg;
        tgt_next       = tgt_reg;
        idx_next       = idx_reg;
        nval_next      = nval_reg;
        load_next      = load_reg;
        phase_next     = phase_reg;
        dir_next       = dir_reg;
        err_next       = err_reg;
        fval_next      = fval_reg;
        fok_next       = fok_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_count_next = out_count_reg;
        out_err_next   = out_err_reg;

        ewe    = 1'b0;
        ewaddr = idx_reg;
        ewdata = nval_reg;
        ere    = 1'b0;
        eraddr = eaddr_t'(request.elem_index);
        fwe    = 1'b0;
        fwaddr = fval_reg;
        fwdata = '0;
        fre    = 1'b0;
        fraddr = vaddr_t'(cur_val);

        unique case (state_reg)
            ST_CLEAR:
            begin
                fwe      = 1'b1;
                fwaddr   = clr_reg;
                clr_next = clr_reg + vaddr_t'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    // The old element is fetched at once in case the load
                    // lands inside the window.
                    ere        = 1'b1;
                    load_next  = !is_query;
                    phase_next = 1'b0;
                    idx_next   = eaddr_t'(request.elem_index);
                    nval_next  = request.elem_value;
                    lo_next    = pos_t'(request.range_left);
                    tgt_next   = pos_t'(hi_p1);
                    err_next   = is_query && q_err;
                end
            end
            ST_WALK:
            begin
                ere = walk_any;
                if (left_gt)
                begin
                    left_next = left_reg - pos_t'(1);
                    eraddr    = eaddr_t'(left_reg - pos_t'(1));
                    dir_next  = 1'b1;
                end
                else if (end_lt)
                begin
                    end_next = end_reg + pos_t'(1);
                    eraddr   = eaddr_t'(end_reg);
                    dir_next = 1'b1;
                end
                else if (left_lt)
                begin
                    left_next = left_reg + pos_t'(1);
                    eraddr    = eaddr_t'(left_reg);
                    dir_next  = 1'b0;
                end
                else if (end_gt)
                begin
                    end_next = end_reg - pos_t'(1);
                    eraddr   = eaddr_t'(end_reg - pos_t'(1));
                    dir_next = 1'b0;
                end
            end
            ST_ELEM:
            begin
                fre       = 1'b1;
                fval_next = vaddr_t'(cur_val);
                fok_next  = (32'(cur_val) < VALUE_RANGE);
            end
            ST_FREQ:
            begin
                // Read-modify-write of one frequency entry. Removing a value
                // whose count is already zero leaves everything unchanged.
                if (fok_reg)
                begin
                    if (cur_dir)
                    begin
                        fwe    = 1'b1;
                        fwdata = frdata + cnt_t'(1);
                        if (frdata == '0)
                        begin
                            distinct_next = distinct_reg + cnt_t'(1);
                        end
                    end
                    else if (frdata != '0)
                    begin
                        fwe    = 1'b1;
                        fwdata = frdata - cnt_t'(1);
                        if (frdata == cnt_t'(1))
                        begin
                            distinct_next = distinct_reg - cnt_t'(1);
                        end
                    end
                end
                if (load_reg)
                begin
                    phase_next = 1'b1;
                end
            end
            ST_LOAD_WR:
            begin
                ewe = 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = dcount_t'(distinct_reg);
                    out_err_next   = err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state, set to its starting values by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            length_reg    <= LEN_RESET;
            left_reg      <= '0;
            end_reg       <= '0;
            distinct_reg  <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            end_reg       <= end_next;
            distinct_reg  <= distinct_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                length_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers of the request in work and of the result.
    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        tgt_reg       <= tgt_next;
        idx_reg       <= idx_next;
        nval_reg      <= nval_next;
        load_reg      <= load_next;
        phase_reg     <= phase_next;
        dir_reg       <= dir_next;
        err_reg       <= err_next;
        fval_reg      <= fval_next;
        fok_reg       <= fok_next;
        out_count_reg <= out_count_next;
        out_err_reg   <= out_err_next;
    end

    // The window edges stay ordered and within the element array, and a
    // result only ever appears out of the finishing state.
    `RDCW_ASSERT(a_window_ordered, clk, rst_n, left_reg <= end_reg)
    `RDCW_ASSERT(a_end_in_array, clk, rst_n, 32'(end_reg) <= MAX_ELEMENTS)
    `RDCW_ASSERT(a_result_from_done, clk, rst_n,
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))

endmodule

FILE: sv/rdcw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module rdcw_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: bench/tb_range_distinct_count_window.sv
// Self-checking bench for the sliding-window distinct-count block with its own window predictor.
`timescale 1ns / 100ps

module tb_range_distinct_count_window;
    import rdcw_pkg::*;

    localparam int RESET_CYCLES       = 6;
    localparam int SETTLE_CYCLES      = 4;
    localparam int DRAIN_CYCLES       = 40;
    localparam int QUIET_LIMIT        = 25000;
    localparam int HOLD_AFTER_RESULTS = 150;
    localparam int HOLD_CYCLES        = 400;
    localparam int RANDOM_ITEMS       = 750;
    localparam int PHASES             = 6;
    localparam int STORE_DEPTH        = DEF_MAX_ELEMENTS;
    localparam int VALUE_SPAN         = DEF_VALUE_RANGE;

    // One request as it crosses the request channel.
    typedef struct
    {
        action_t action;
        idx_t    elem_index;
        val_t    elem_value;
        idx_t    range_left;
        idx_t    range_right;
    } request_t;

    // The answer the block owes for one accepted request.
    typedef struct
    {
        dcount_t count;
        logic    flagged;
    } count_answer_t;

    // Keeps a private copy of the element store, the value histogram and the window edges,
    // works out the answer of every accepted request and compares returned answers in order.
    class distinct_scoreboard;
        len_t          length_reg;
        val_t          element_mem [STORE_DEPTH];
        int unsigned   value_hits [VALUE_SPAN];
        int unsigned   win_left;
        int unsigned   win_end;
        int unsigned   distinct_now;
        count_answer_t answers_due [$];
        int unsigned   mismatches;

        function new();
            length_reg = LEN_RESET;
            foreach (element_mem[i])
                element_mem[i] = '0;
            foreach (value_hits[i])
                value_hits[i] = 0;
            win_left     = 0;
            win_end      = 0;
            distinct_now = 0;
            mismatches   = 0;
        endfunction

        function void set_length(len_t v);
            length_reg = v;
        endfunction

        // A register above the store size is clipped to the store size.
        function int unsigned usable_length();
            return (length_reg > STORE_DEPTH) ? STORE_DEPTH : int'(length_reg);
        endfunction

        function void add_value(val_t v);
            value_hits[v]++;
            if (value_hits[v] == 1)
                distinct_now++;
        endfunction

        function void drop_value(val_t v);
            if (value_hits[v] != 0)
            begin
                value_hits[v]--;
                if (value_hits[v] == 0)
                    distinct_now--;
            end
        endfunction

        function void note_request(request_t r);
            count_answer_t ans;
            int unsigned   lo;
            int unsigned   stop;
            ans.flagged = 1'b0;
            if (r.action == ACT_LOAD)
            begin
                // A write that lands inside the window swaps the old value for the new one.
                if (r.elem_index >= win_left && r.elem_index < win_end)
                begin
                    drop_value(element_mem[r.elem_index]);
                    add_value(r.elem_value);
                end
                element_mem[r.elem_index] = r.elem_value;
            end
            else
            begin
                lo   = r.range_left;
                stop = r.range_right;
                stop = stop + 1;
                if (lo > stop || r.range_right >= usable_length())
                    ans.flagged = 1'b1;
                else
                begin
                    // Grow first, then shrink, one element at a time.
                    while (win_left > lo)
                    begin
                        win_left--;
                        add_value(element_mem[win_left]);
                    end
                    while (win_end < stop)
                    begin
                        add_value(element_mem[win_end]);
                        win_end++;
                    end
                    while (win_left < lo)
                    begin
                        drop_value(element_mem[win_left]);
                        win_left++;
                    end
                    while (win_end > stop)
                    begin
                        win_end--;
                        drop_value(element_mem[win_end]);
                    end
                    if (win_left > win_end)
                        win_left = win_end;
                end
            end
            ans.count = dcount_t'(distinct_now);
            answers_due.insert(answers_due.size(), ans);
        endfunction

        function void check_result(dcount_t got_count, logic got_flag);
            count_answer_t want;
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected result, count %0d error %0b", $time,
                         got_count, got_flag);
                mismatches++;
                return;
            end
            want = answers_due.pop_front();
            if (got_count !== want.count)
            begin
                $display("%0t: distinct_count expected %0d actual %0d", $time,
                         want.count, got_count);
                mismatches++;
            end
            if (got_flag !== want.flagged)
            begin
                $display("%0t: range_error expected %0b actual %0b", $time,
                         want.flagged, got_flag);
                mismatches++;
            end
        endfunction
    endclass

    typedef enum
    {
        TAKE_ALL,
        TAKE_HALF,
        TAKE_EVERY_FOURTH,
        TAKE_MOST
    } take_mode_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    len_t cfg_wr_data;

    rdcw_req_if req_ch ();
    rdcw_rsp_if rsp_ch ();

    distinct_scoreboard board = new();

    // Positions written since reset, and the length of the fully written run from zero.
    // Every query that can move the window stays inside that run, so the walk never
    // touches an element that was never loaded.
    bit written [STORE_DEPTH];
    int filled;
    int aim_left;
    int value_base;
    int burst_left;
    bit receiver_holding;

    int loads_seen;
    int queries_seen;
    int flagged_seen;
    int results_taken;
    int length_writes;

    range_distinct_count_window i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (req_ch),
        .result      (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // Every handshake is sampled at the rising edge, before any of that edge's updates land.
    always @(posedge clk)
    begin : handshake_monitor
        request_t seen;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                board.check_result(rsp_ch.distinct_count, rsp_ch.range_error);
                results_taken++;
                if (rsp_ch.range_error)
                    flagged_seen++;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen.action      = req_ch.action;
                seen.elem_index  = req_ch.elem_index;
                seen.elem_value  = req_ch.elem_value;
                seen.range_left  = req_ch.range_left;
                seen.range_right = req_ch.range_right;
                board.note_request(seen);
                if (seen.action == ACT_LOAD)
                    loads_seen++;
                else
                    queries_seen++;
            end
        end
    end

    // The result side takes answers on a pattern of its own: stretches of full rate,
    // coin tosses, one in four, and mostly ready. Once, after a fair number of results,
    // it refuses for a long stretch so that the block backs up and stalls requests.
    initial
    begin : result_taker
        take_mode_t mode;
        int         seg_len;
        int         n;
        bit         hold_done;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!hold_done && results_taken >= HOLD_AFTER_RESULTS)
            begin
                hold_done = 1'b1;
                receiver_holding = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                receiver_holding = 1'b0;
            end
            mode    = take_mode_t'($urandom_range(0, 3));
            seg_len = $urandom_range(8, 120);
            for (n = 0; n < seg_len; n++)
            begin
                case (mode)
                    TAKE_ALL:          rsp_ch.ready <= 1'b1;
                    TAKE_HALF:         rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                    TAKE_EVERY_FOURTH: rsp_ch.ready <= (n % 4 == 3);
                    default:           rsp_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Ends the run if neither channel moves for too long. The slowest honest gap is a
    // query that walks the window across the whole store while the result side holds off.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Drops the request valid and waits until every answer owed has come back.
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (board.answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The length register is only ever changed with no answers outstanding.
    task automatic write_length(input len_t v);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_length(v);
        length_writes++;
    endtask

    // Offers one request in bursts of random length; a gap between bursts is skipped while
    // the result side is holding off, so the request side keeps pushing against the stall.
    task automatic send_request(input request_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = receiver_holding ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_ch.valid       <= 1'b1;
        req_ch.action      <= r.action;
        req_ch.elem_index  <= r.elem_index;
        req_ch.elem_value  <= r.elem_value;
        req_ch.range_left  <= r.range_left;
        req_ch.range_right <= r.range_right;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // The fields a request does not use carry random junk, which the block must ignore.
    task automatic send_load(input int idx, input int val);
        request_t r;
        r.action      = ACT_LOAD;
        r.elem_index  = idx_t'(idx);
        r.elem_value  = val_t'(val);
        r.range_left  = idx_t'($urandom);
        r.range_right = idx_t'($urandom);
        written[idx] = 1'b1;
        while (filled < STORE_DEPTH && written[filled])
            filled++;
        send_request(r);
    endtask

    task automatic send_query(input int lo, input int hi);
        request_t r;
        r.action      = ACT_QUERY;
        r.elem_index  = idx_t'($urandom);
        r.elem_value  = val_t'($urandom);
        r.range_left  = idx_t'(lo);
        r.range_right = idx_t'(hi);
        send_request(r);
    endtask

    // Mostly a narrow band of values so that ranges hold repeats, now and then any value.
    function automatic int pick_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, VALUE_SPAN - 1);
        return value_base + $urandom_range(0, 11);
    endfunction

    // One random request. Loads mostly extend the written run; queries mostly sit near the
    // previous one so the walk stays short, with some wide, empty and out-of-range ones.
    task automatic random_item();
        int roll;
        int lim;
        int lo;
        int hi;
        int usable;
        roll = $urandom_range(0, 99);
        if (roll >= 35)
        begin
            if (roll < 85 && filled < STORE_DEPTH)
                send_load(filled, pick_value());
            else
                send_load($urandom_range(0, STORE_DEPTH - 1), pick_value());
        end
        else
        begin
            usable = board.usable_length();
            lim    = (usable < filled) ? usable : filled;
            if (lim == 0 || roll < 4)
            begin
                // Bounds the block has to refuse without touching the window.
                if (usable < STORE_DEPTH && $urandom_range(0, 1) == 1)
                begin
                    hi = $urandom_range(usable, STORE_DEPTH - 1);
                    lo = $urandom_range(0, STORE_DEPTH - 1);
                end
                else
                begin
                    hi = $urandom_range(0, STORE_DEPTH - 3);
                    lo = $urandom_range(hi + 2, STORE_DEPTH - 1);
                end
            end
            else if (roll < 8)
            begin
                // Empty range: left one past right, the window collapses.
                lo = $urandom_range(1, lim);
                hi = lo - 1;
                aim_left = lo;
            end
            else if (roll < 11)
            begin
                lo = $urandom_range(0, lim - 1);
                hi = $urandom_range(lo, lim - 1);
                aim_left = lo;
            end
            else
            begin
                lo = aim_left - 16 + int'($urandom_range(0, 32));
                if (lo < 0)
                    lo = 0;
                if (lo > lim - 1)
                    lo = lim - 1;
                hi = lo + $urandom_range(0, 24);
                if (hi > lim - 1)
                    hi = lim - 1;
                aim_left = lo;
            end
            send_query(lo, hi);
        end
    endtask

    initial
    begin : stimulus
        int   ph;
        len_t phase_len;
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= ACT_LOAD;
        req_ch.elem_index  <= '0;
        req_ch.elem_value  <= '0;
        req_ch.range_left  <= '0;
        req_ch.range_right <= '0;
        filled           = 0;
        aim_left         = 0;
        value_base       = 0;
        burst_left       = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // The block is still clearing its histogram here; the register is taken anyway.
        write_length(LEN_RESET);

        // Fill the first eight positions with the extreme values among others, some of them repeated,
        // and the very last position of the store as well.
        send_load(0, 0);
        send_load(1, VALUE_SPAN - 1);
        send_load(2, 0);
        send_load(3, 512);
        send_load(4, VALUE_SPAN - 1);
        send_load(5, 341);
        send_load(6, 682);
        send_load(7, 0);
        send_load(STORE_DEPTH - 1, VALUE_SPAN - 1);

        // Whole loaded run, a single element, an empty range, the last element, then
        // left beyond right plus one, both with a small and with the largest left bound.
        send_query(0, 7);
        send_query(0, 0);
        send_query(3, 2);
        send_query(7, 7);
        send_query(5, 2);
        send_query(STORE_DEPTH - 1, 5);
        send_query(2, 6);

        // Writes inside the window: one swaps a value for a fresh one, one creates a
        // repeat and so lowers the count. A write outside the window leaves it alone.
        send_load(4, 7);
        send_load(3, 0);
        send_load(9, 100);
        send_query(2, 6);

        // A length of zero refuses every query.
        write_length(len_t'(0));
        send_query(0, 0);

        // A length beyond the store behaves as the full store.
        write_length('1);
        send_query(1, 5);

        // The shortest legal length: one element, its empty range, and the top bound refused.
        write_length(len_t'(1));
        send_query(0, 0);
        send_query(1, 0);
        send_query(0, STORE_DEPTH - 1);

        // Random phases, each under its own length setting, the extremes among them.
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       phase_len = LEN_RESET;
                1:       phase_len = len_t'($urandom_range(16, STORE_DEPTH));
                2:       phase_len = len_t'(1);
                3:       phase_len = '1;
                4:       phase_len = len_t'($urandom_range(1, STORE_DEPTH));
                default: phase_len = LEN_RESET;
            endcase
            write_length(phase_len);
            value_base = $urandom_range(0, VALUE_SPAN - 12);
            repeat (RANDOM_ITEMS / PHASES) random_item();
        end

        settle_block();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d loads and %0d range queries (%0d refused) over %0d length settings.",
                 loads_seen, queries_seen, flagged_seen, length_writes);
        $display("Checked %0d results; the loaded run reached %0d elements.",
                 results_taken, filled);
        if (board.mismatches == 0 && board.answers_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
